[design/header_length_crc8_frame_parser_top_assert.svh]
// Assertion macros used by the frame parser core
`ifndef HEADER_LENGTH_CRC8_FRAME_PARSER_TOP_ASSERT_SVH
`define HEADER_LENGTH_CRC8_FRAME_PARSER_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define HLCFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define HLCFP_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[design/hlcfp_pkg.sv]
// Package: constants, result type and CRC-8 step function for the frame parser
package hlcfp_pkg;

   localparam int HEADER_LEN = 2;
   localparam int POS_W      = 9;
   localparam int BYTE_W     = 8;

   localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_TOP   = 8'h80;
   localparam logic [BYTE_W-1:0] END_BASE  = BYTE_W'(HEADER_LEN + 1);
   localparam logic [POS_W-1:0]  POS_HDR   = POS_W'(HEADER_LEN);
   localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(256);

   typedef struct packed {
      logic              payload_strobe;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_done;
      logic              crc_match;
      logic [BYTE_W-1:0] frame_length;
   } rsp_type;

   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] v;
      v = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((v & CRC_TOP) != '0) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

endpackage

[design/hlcfp_channels_if.sv]
// Valid/ready channel interfaces for the byte input and the result output
interface hlcfp_req_if;
   logic                         valid;
   logic                         ready;
   logic [hlcfp_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface hlcfp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         payload_strobe;
   logic [hlcfp_pkg::BYTE_W-1:0] payload_byte;
   logic                         frame_done;
   logic                         crc_match;
   logic [hlcfp_pkg::BYTE_W-1:0] frame_length;

   modport source (output valid, output payload_strobe, output payload_byte,
                   output frame_done, output crc_match, output frame_length,
                   input ready);
   modport sink   (input valid, input payload_strobe, input payload_byte,
                   input frame_done, input crc_match, input frame_length,
                   output ready);
endinterface

[design/hlcfp_in_stage.sv]
// Input register stage: holds one received byte until the parser core takes it
module hlcfp_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   hlcfp_req_if.sink                    req_channel,
   input  logic                         take,
   output logic                         held_valid,
   output logic [hlcfp_pkg::BYTE_W-1:0] held_byte
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [hlcfp_pkg::BYTE_W-1:0] byte_ff;
   logic                         load;

   assign req_channel.ready = !valid_ff || take;
   assign load              = req_channel.valid && req_channel.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_channel.data_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

[design/hlcfp_core.sv]
// Parser core: header match, length capture, CRC-8 over payload, check byte compare
`include "header_length_crc8_frame_parser_top_assert.svh"

module hlcfp_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [31:0]                  csr_write_data,
   input  logic                         step,
   input  logic [hlcfp_pkg::BYTE_W-1:0] data_byte,
   output hlcfp_pkg::rsp_type           result
);

   logic [31:0]                  header_bytes_ff;
   logic [hlcfp_pkg::POS_W-1:0]  position_ff;
   logic [hlcfp_pkg::POS_W-1:0]  position_in;
   logic [hlcfp_pkg::BYTE_W-1:0] end_position_ff;
   logic [hlcfp_pkg::BYTE_W-1:0] end_position_in;
   logic [hlcfp_pkg::BYTE_W-1:0] running_crc_ff;
   logic [hlcfp_pkg::BYTE_W-1:0] running_crc_in;
   logic                         frame_complete_ff;
   logic                         frame_complete_in;
   logic [hlcfp_pkg::BYTE_W-1:0] length_value_ff;
   logic [hlcfp_pkg::BYTE_W-1:0] length_value_in;

   logic [hlcfp_pkg::POS_W-1:0]  end_ext;
   logic [hlcfp_pkg::POS_W-1:0]  position_next;
   logic [hlcfp_pkg::BYTE_W-1:0] header_first;
   logic [hlcfp_pkg::BYTE_W-1:0] header_here;

   assign end_ext       = {1'b0, end_position_ff};
   assign position_next = position_ff + hlcfp_pkg::POS_W'(1);
   assign header_first  = header_bytes_ff[hlcfp_pkg::BYTE_W-1:0];
   assign header_here   = header_bytes_ff[{position_ff[1:0], 3'b000} +: hlcfp_pkg::BYTE_W];

   always_comb begin
      position_in       = position_ff;
      end_position_in   = end_position_ff;
      running_crc_in    = running_crc_ff;
      frame_complete_in = frame_complete_ff;
      length_value_in   = length_value_ff;
      result            = '0;
      if (position_ff == hlcfp_pkg::POS_HDR) begin
         length_value_in = data_byte;
         end_position_in = hlcfp_pkg::END_BASE + data_byte;
         position_in     = position_next;
      end else if (position_ff > hlcfp_pkg::POS_HDR && position_ff < end_ext) begin
         running_crc_in        = hlcfp_pkg::crc8_byte(running_crc_ff, data_byte);
         result.payload_strobe = 1'b1;
         result.payload_byte   = data_byte;
         position_in           = position_next;
      end else if (position_ff == end_ext) begin
         frame_complete_in = 1'b1;
         result.frame_done = 1'b1;
         result.crc_match  = (running_crc_ff == data_byte);
         position_in       = position_next;
      end else if ((position_ff == '0 || frame_complete_ff) && header_first == data_byte) begin
         // restart the frame
         position_in       = hlcfp_pkg::POS_W'(1);
         end_position_in   = '1;
         running_crc_in    = '0;
         frame_complete_in = 1'b0;
         length_value_in   = '0;
      end else if (position_ff < hlcfp_pkg::POS_HDR && header_here == data_byte) begin
         position_in = position_next;
      end
      result.frame_length = length_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff <= '0;
      end else if (csr_write_enable) begin
         header_bytes_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff       <= '0;
         end_position_ff   <= '1;
         running_crc_ff    <= '0;
         frame_complete_ff <= 1'b0;
         length_value_ff   <= '0;
      end else if (step) begin
         position_ff       <= position_in;
         end_position_ff   <= end_position_in;
         running_crc_ff    <= running_crc_in;
         frame_complete_ff <= frame_complete_in;
         length_value_ff   <= length_value_in;
      end
   end

   `HLCFP_NEVER(a_position_bound, position_ff > hlcfp_pkg::POS_LIMIT, "position beyond 256")
   `HLCFP_NEVER(a_done_no_strobe, result.frame_done && result.payload_strobe, "strobe on check byte")
   `HLCFP_NEVER(a_match_needs_done, result.crc_match && !result.frame_done, "match without done")
   `HLCFP_ASSERT(a_payload_advances, step && result.payload_strobe |=> position_ff == $past(position_next), "payload byte did not advance")

endmodule

[design/hlcfp_out_stage.sv]
// Result register stage: holds one result beat until the sink takes it
module hlcfp_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  hlcfp_pkg::rsp_type result,
   output logic               can_load,
   hlcfp_rsp_if.source        rsp_channel
);

   logic               valid_ff;
   logic               valid_in;
   hlcfp_pkg::rsp_type result_ff;

   assign can_load = !valid_ff || rsp_channel.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_channel.valid          = valid_ff;
   assign rsp_channel.payload_strobe = result_ff.payload_strobe;
   assign rsp_channel.payload_byte   = result_ff.payload_byte;
   assign rsp_channel.frame_done     = result_ff.frame_done;
   assign rsp_channel.crc_match      = result_ff.crc_match;
   assign rsp_channel.frame_length   = result_ff.frame_length;

endmodule

[design/header_length_crc8_frame_parser_top.sv]
// Length-prefixed frame parser with CRC-8 check, one byte per beat.
// Each accepted byte yields exactly one result beat. A byte is held in the
// input register, decoded by the parser core and written to the result
// register once that register can take it, and a new byte is taken every
// cycle while the result side keeps up. A frame is HEADER_LEN header bytes
// (matched against csr_write_data, byte i in bits 8i+7..8i), a length byte,
// that many payload bytes streamed out with payload_strobe, and a check byte
// compared with the CRC-8 (poly 0x07, init 0, MSB first). Write the header
// register only while no beat is in flight. A length that wraps the 8-bit
// end position parks the parser until reset.
module header_length_crc8_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   hlcfp_req_if.sink   req_channel,
   hlcfp_rsp_if.source rsp_channel
);

   logic                         held_valid;
   logic [hlcfp_pkg::BYTE_W-1:0] held_byte;
   logic                         out_can_load;
   logic                         step;
   hlcfp_pkg::rsp_type           result;

   assign step = held_valid && out_can_load;

   hlcfp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .take        (step),
      .held_valid  (held_valid),
      .held_byte   (held_byte)
   );

   hlcfp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .data_byte        (held_byte),
      .result           (result)
   );

   hlcfp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (step),
      .result      (result),
      .can_load    (out_can_load),
      .rsp_channel (rsp_channel)
   );

endmodule
